[sv/rim_pkg.sv]
// ----------------------------------------------------------------------------
// rim_pkg: shared types for the integer multiplier unit
// Command codes and the payloads that pass between the pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package rim_pkg;

   localparam int unsigned XLEN = 64;
   localparam int unsigned HALF = XLEN / 2;

   // command codes; the two codes above the word variants return zero
   typedef enum logic [2:0] {
      CMD_MUL    = 3'd0,
      CMD_MULH   = 3'd1,
      CMD_MULHSU = 3'd2,
      CMD_MULHU  = 3'd3,
      CMD_MULW   = 3'd4,
      CMD_MULWU  = 3'd5
   } cmd_type;

   // request as it enters the first stage
   typedef struct packed {
      logic [2:0]      command;
      logic [XLEN-1:0] operand_a;
      logic [XLEN-1:0] operand_b;
   } req_type;

   // after the partial products
   typedef struct packed {
      logic [2:0]      command;
      logic [XLEN-1:0] pp_ll;
      logic [XLEN-1:0] pp_lh;
      logic [XLEN-1:0] pp_hl;
      logic [XLEN-1:0] pp_hh;
      logic [XLEN-1:0] corr;
   } prod_type;

   // after the column sums
   typedef struct packed {
      logic [2:0]      command;
      logic [XLEN-1:0] lo;
      logic [XLEN-1:0] hi_part;
      logic [1:0]      mid_carry;
      logic [XLEN-1:0] corr;
   } sum_type;

endpackage

`default_nettype wire

[sv/rim_mul_stage.sv]
// ----------------------------------------------------------------------------
// rim_mul_stage: partial product stage
// Forms the four 32x32 partial products and the signed high-half correction.
// ----------------------------------------------------------------------------
`default_nettype none

module rim_mul_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire rim_pkg::req_type  in_data,
   output logic                   in_ready,
   output logic                   out_valid,
   output rim_pkg::prod_type      out_data,
   input  wire logic              out_ready
);
   import rim_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   prod_type          data_ff;
   prod_type          data_in;
   logic [HALF-1:0]   a_lo;
   logic [HALF-1:0]   a_hi;
   logic [HALF-1:0]   b_lo;
   logic [HALF-1:0]   b_hi;
   logic [XLEN-1:0]   corr_a;
   logic [XLEN-1:0]   corr_b;
   cmd_type           cmd;

   // take a new transfer when empty or when the next stage takes ours
   assign in_ready = !valid_ff || out_ready;

   // split operands and build the products and the correction term
   always_comb begin
      cmd    = cmd_type'(in_data.command);
      a_lo   = in_data.operand_a[HALF-1:0];
      a_hi   = in_data.operand_a[XLEN-1:HALF];
      b_lo   = in_data.operand_b[HALF-1:0];
      b_hi   = in_data.operand_b[XLEN-1:HALF];
      corr_a = '0;
      corr_b = '0;
      case (cmd)
         CMD_MULH: begin
            corr_a = in_data.operand_a[XLEN-1] ? in_data.operand_b : '0;
            corr_b = in_data.operand_b[XLEN-1] ? in_data.operand_a : '0;
         end
         CMD_MULHSU: begin
            corr_a = in_data.operand_a[XLEN-1] ? in_data.operand_b : '0;
         end
         default: begin
            corr_a = '0;
            corr_b = '0;
         end
      endcase
      data_in.command = in_data.command;
      data_in.pp_ll   = XLEN'(a_lo) * XLEN'(b_lo);
      data_in.pp_lh   = XLEN'(a_lo) * XLEN'(b_hi);
      data_in.pp_hl   = XLEN'(a_hi) * XLEN'(b_lo);
      data_in.pp_hh   = XLEN'(a_hi) * XLEN'(b_hi);
      data_in.corr    = corr_a + corr_b;
      valid_in        = in_ready ? in_valid : valid_ff;
   end

   // hold on stall, advance otherwise
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[sv/rim_sum_stage.sv]
// ----------------------------------------------------------------------------
// rim_sum_stage: column sum stage
// Adds the partial products into the low word and a partial high word.
// ----------------------------------------------------------------------------
`default_nettype none

module rim_sum_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire rim_pkg::prod_type  in_data,
   output logic                    in_ready,
   output logic                    out_valid,
   output rim_pkg::sum_type        out_data,
   input  wire logic               out_ready
);
   import rim_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   sum_type         data_ff;
   sum_type         data_in;
   logic [HALF+1:0] mid;

   assign in_ready = !valid_ff || out_ready;

   // sum the middle column, then the high column without the middle carry
   always_comb begin
      mid = (HALF+2)'(in_data.pp_ll[XLEN-1:HALF])
          + (HALF+2)'(in_data.pp_lh[HALF-1:0])
          + (HALF+2)'(in_data.pp_hl[HALF-1:0]);
      data_in.command   = in_data.command;
      data_in.lo        = {mid[HALF-1:0], in_data.pp_ll[HALF-1:0]};
      data_in.hi_part   = in_data.pp_hh
                        + XLEN'(in_data.pp_lh[XLEN-1:HALF])
                        + XLEN'(in_data.pp_hl[XLEN-1:HALF]);
      data_in.mid_carry = mid[HALF+1:HALF];
      data_in.corr      = in_data.corr;
      valid_in          = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

[sv/rim_sel_stage.sv]
// ----------------------------------------------------------------------------
// rim_sel_stage: result stage
// Finishes the high word, applies the sign correction and selects the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rim_sel_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire rim_pkg::sum_type  in_data,
   output logic                   in_ready,
   output logic                   out_valid,
   output logic [63:0]            out_product,
   input  wire logic              out_stall
);
   import rim_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   logic [XLEN-1:0] product_ff;
   logic [XLEN-1:0] product_in;
   logic [XLEN-1:0] hi;
   cmd_type         cmd;

   assign in_ready = !valid_ff || !out_stall;

   // finish the high word and pick the requested half
   always_comb begin
      cmd = cmd_type'(in_data.command);
      hi  = in_data.hi_part + XLEN'(in_data.mid_carry) - in_data.corr;
      case (cmd)
         CMD_MUL:    product_in = in_data.lo;
         CMD_MULH:   product_in = hi;
         CMD_MULHSU: product_in = hi;
         CMD_MULHU:  product_in = hi;
         CMD_MULW:   product_in = {{HALF{in_data.lo[HALF-1]}}, in_data.lo[HALF-1:0]};
         CMD_MULWU:  product_in = {{HALF{1'b0}}, in_data.lo[HALF-1:0]};
         default:    product_in = '0;
      endcase
      valid_in = in_ready ? in_valid : valid_ff;
   end

   // hold the result while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         product_ff <= product_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_product = product_ff;

endmodule

`default_nettype wire

[sv/riscv_integer_multiplier_unit.sv]
// ----------------------------------------------------------------------------
// riscv_integer_multiplier_unit: pipelined 64-bit integer multiplier
// Low, high (signed, mixed, unsigned) and word products of two 64-bit operands.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfer carries req_command, req_operand_a and req_operand_b;
//   it completes on a clock edge with req_valid high and req_stall low.
//   The result comes back on rsp_product, one per request, in request order,
//   and completes on an edge with rsp_valid high and rsp_stall low.
//   The path has 3 register stages: the partial product stage (four 32x32
//   multipliers), the column sum stage and the correction/select stage.
//   One request per cycle is accepted while req_stall is low, and a new
//   request enters behind the previous one before that one has left.
//   While rsp_stall is high the held result stays on rsp_product; stages
//   behind it keep filling their empty slots, and req_stall rises once
//   every stage holds an item. Nothing is dropped or repeated.
//   A synchronous reset empties the pipeline; rsp_valid is low after it.
//   Command codes 6 and 7 return zero.
// ----------------------------------------------------------------------------
`default_nettype none

module riscv_integer_multiplier_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [2:0]   req_command,
   input  wire logic [63:0]  req_operand_a,
   input  wire logic [63:0]  req_operand_b,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [63:0]       rsp_product
);
   import rim_pkg::*;

   req_type  req;
   prod_type prod;
   sum_type  sum;
   logic     s1_ready;
   logic     s1_valid;
   logic     s2_ready;
   logic     s2_valid;
   logic     s3_ready;

   // gather the request fields
   assign req.command   = req_command;
   assign req.operand_a = req_operand_a;
   assign req.operand_b = req_operand_b;
   assign req_stall     = !s1_ready;

   rim_mul_stage u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req),
      .in_ready  (s1_ready),
      .out_valid (s1_valid),
      .out_data  (prod),
      .out_ready (s2_ready)
   );

   rim_sum_stage u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_data   (prod),
      .in_ready  (s2_ready),
      .out_valid (s2_valid),
      .out_data  (sum),
      .out_ready (s3_ready)
   );

   rim_sel_stage u_sel (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s2_valid),
      .in_data     (sum),
      .in_ready    (s3_ready),
      .out_valid   (rsp_valid),
      .out_product (rsp_product),
      .out_stall   (rsp_stall)
   );

endmodule

`default_nettype wire

[sv/rim_checker.sv]
// ----------------------------------------------------------------------------
// rim_checker: port-level checks for the integer multiplier unit
// Watches the request and response channels and the fixed pipeline latency.
// ----------------------------------------------------------------------------
`default_nettype none

module rim_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire logic [2:0]   req_command,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire logic [63:0]  rsp_product
);
   import rim_pkg::*;

   logic req_xfer;

   assign req_xfer = req_valid && !req_stall;

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // an empty output stage never pushes back on requests
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

   // without back-pressure an accepted request shows up as a valid response
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_xfer ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("result missing after pipeline latency");

   // word multiply returns a sign-extended low word
   a_word_sext: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_command == CMD_MULW) ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_product[63:32] == {32{rsp_product[31]}})
      else $error("word result not sign-extended");

   // unused commands return zero
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_command > 3'(CMD_MULWU)) ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_product == 64'd0)
      else $error("unused command returned nonzero");

endmodule

bind riscv_integer_multiplier_unit rim_checker u_rim_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_command (req_command),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_product (rsp_product)
);

`default_nettype wire
